[rtl/s256_pkg.sv]
// ============================================================================
// s256_pkg
// Shared types and constants for the SHA-256 byte stream hash.
// ============================================================================
`default_nettype none

package s256_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic [5:0] FILL_LAST  = 6'd63;
    localparam logic [5:0] FILL_LEN   = 6'd56;
    localparam logic [5:0] ROUND_LAST = 6'd63;
    localparam logic [2:0] WORD_LAST  = 3'd7;
    localparam logic [7:0] PAD_BYTE   = 8'h80;

    typedef logic [31:0] s256_words_t [8];

    // Command held in the queue between the front and the back end
    typedef struct packed {
        logic       byte_present;
        logic [7:0] data_byte;
        logic       end_of_message;
    } s256_cmd_t;

    // Control from the sequencer to the compression datapath
    typedef struct packed {
        logic       shift_byte;
        logic [7:0] byte_val;
        logic       start;
        logic       round;
        logic [5:0] round_idx;
        logic       update;
        logic       reinit;
    } s256_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_UPDATE,
        ST_PAD_ONE,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_EMIT
    } s256_state_t;

    localparam s256_words_t INIT_CHAIN = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

endpackage

`default_nettype wire

[rtl/s256_front.sv]
// ============================================================================
// s256_front
// Input front end: takes items, drops those carrying neither a byte nor an
// end mark, and queues the rest for the back end.
// ============================================================================
`default_nettype none

module s256_front (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [7:0]         data_byte,
    input  wire logic               byte_present,
    input  wire logic               end_of_message,
    output logic                    cmd_valid,
    output s256_pkg::s256_cmd_t     cmd,
    input  wire logic               cmd_pop
);
    import s256_pkg::*;

    s256_cmd_t             queue_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   wr_ptr_reg;
    logic [QUEUE_AW-1:0]   rd_ptr_reg;
    logic [QUEUE_CW-1:0]   count_reg;
    logic                  push;

    assign in_ready  = (count_reg != QUEUE_CW'(QUEUE_DEPTH));
    // empty items are taken and dropped here
    assign push      = in_valid && in_ready && (byte_present || end_of_message);
    assign cmd_valid = (count_reg != '0);
    assign cmd       = queue_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= '{byte_present: byte_present,
                                       data_byte: data_byte,
                                       end_of_message: end_of_message};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (cmd_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !cmd_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (!push && cmd_pop)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/s256_compress.sv]
// ============================================================================
// s256_compress
// Compression datapath: 512-bit message window, working variables and
// chaining value, one round per cycle.
// ============================================================================
`default_nettype none

module s256_compress (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire s256_pkg::s256_ctl_t ctl,
    output s256_pkg::s256_words_t   chain
);
    import s256_pkg::*;

    function automatic logic [31:0] ror(input logic [31:0] x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    s256_words_t   chain_reg;
    s256_words_t   vars_reg;
    logic [511:0]  window_reg;

    logic [31:0]   w0, w1, w9, w14, w_new;
    logic [31:0]   sum_e, ch, sum_a, maj, t1, t2;

    // window holds W[t] .. W[t+15], W[t] in the top word
    assign w0  = window_reg[511:480];
    assign w1  = window_reg[479:448];
    assign w9  = window_reg[223:192];
    assign w14 = window_reg[63:32];

    assign w_new = w0 + (ror(w1, 7) ^ ror(w1, 18) ^ (w1 >> 3)) + w9
                 + (ror(w14, 17) ^ ror(w14, 19) ^ (w14 >> 10));

    assign sum_e = ror(vars_reg[4], 6) ^ ror(vars_reg[4], 11) ^ ror(vars_reg[4], 25);
    assign ch    = (vars_reg[4] & vars_reg[5]) ^ (~vars_reg[4] & vars_reg[6]);
    assign t1    = vars_reg[7] + sum_e + ch + ROUND_K[ctl.round_idx] + w0;
    assign sum_a = ror(vars_reg[0], 2) ^ ror(vars_reg[0], 13) ^ ror(vars_reg[0], 22);
    assign maj   = (vars_reg[0] & vars_reg[1]) ^ (vars_reg[0] & vars_reg[2])
                 ^ (vars_reg[1] & vars_reg[2]);
    assign t2    = sum_a + maj;

    assign chain = chain_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.shift_byte)
        begin
            window_reg <= {window_reg[503:0], ctl.byte_val};
        end
        else if (ctl.round)
        begin
            window_reg <= {window_reg[479:0], w_new};
        end

        if (ctl.start)
        begin
            vars_reg <= chain_reg;
        end
        else if (ctl.round)
        begin
            vars_reg <= '{t1 + t2, vars_reg[0], vars_reg[1], vars_reg[2],
                          vars_reg[3] + t1, vars_reg[4], vars_reg[5], vars_reg[6]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg <= INIT_CHAIN;
        end
        else if (ctl.update)
        begin
            for (int i = 0; i < 8; i++)
            begin
                chain_reg[i] <= chain_reg[i] + vars_reg[i];
            end
        end
        else if (ctl.reinit)
        begin
            chain_reg <= INIT_CHAIN;
        end
    end

endmodule

`default_nettype wire

[rtl/s256_core.sv]
// ============================================================================
// s256_core
// Back-end sequencer: packs bytes, pads the message, runs the round counter
// and streams the digest words through the output register.
// ============================================================================
`default_nettype none

module s256_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                cmd_valid,
    input  wire s256_pkg::s256_cmd_t cmd,
    output logic                     cmd_pop,
    output s256_pkg::s256_ctl_t      ctl,
    input  wire s256_pkg::s256_words_t chain,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic [31:0]              digest_word,
    output logic [2:0]               word_index,
    output logic                     last_word
);
    import s256_pkg::*;

    s256_state_t  state_reg, state_next;
    s256_state_t  ret_reg, ret_next;
    logic [5:0]   round_reg;
    logic [5:0]   fill_reg;
    logic [60:0]  count_reg;
    logic [63:0]  len_reg;
    logic [2:0]   emit_reg;
    logic         out_valid_reg;
    logic [31:0]  digest_reg;
    logic [2:0]   index_reg;
    logic         last_reg;
    logic         out_load;

    // next state
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd.byte_present && fill_reg == FILL_LAST)
                    begin
                        state_next = ST_ROUND;
                        ret_next   = cmd.end_of_message ? ST_PAD_ONE : ST_IDLE;
                    end
                    else if (cmd.end_of_message)
                    begin
                        state_next = ST_PAD_ONE;
                    end
                end
            end
            ST_ROUND:
            begin
                if (round_reg == ROUND_LAST)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ret_reg;
            end
            ST_PAD_ONE:
            begin
                if (fill_reg == FILL_LAST)
                begin
                    state_next = ST_ROUND;
                    ret_next   = ST_PAD_ZERO;
                end
                else
                begin
                    state_next = ST_PAD_ZERO;
                end
            end
            ST_PAD_ZERO:
            begin
                if (fill_reg == FILL_LEN)
                begin
                    state_next = ST_PAD_LEN;
                end
                else if (fill_reg == FILL_LAST)
                begin
                    state_next = ST_ROUND;
                    ret_next   = ST_PAD_ZERO;
                end
            end
            ST_PAD_LEN:
            begin
                if (fill_reg == FILL_LAST)
                begin
                    state_next = ST_ROUND;
                    ret_next   = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_load && emit_reg == WORD_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd_pop  = 1'b0;
        out_load = 1'b0;
        ctl      = '0;
        ctl.round_idx = round_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_pop        = cmd_valid;
                ctl.shift_byte = cmd_valid && cmd.byte_present;
                ctl.byte_val   = cmd.data_byte;
            end
            ST_ROUND:
            begin
                ctl.round = 1'b1;
            end
            ST_UPDATE:
            begin
                ctl.update = 1'b1;
            end
            ST_PAD_ONE:
            begin
                ctl.shift_byte = 1'b1;
                ctl.byte_val   = PAD_BYTE;
            end
            ST_PAD_ZERO:
            begin
                ctl.shift_byte = (fill_reg != FILL_LEN);
            end
            ST_PAD_LEN:
            begin
                ctl.shift_byte = 1'b1;
                ctl.byte_val   = len_reg[63:56];
            end
            ST_EMIT:
            begin
                out_load   = !out_valid_reg || out_ready;
                ctl.reinit = out_load && (emit_reg == WORD_LAST);
            end
            default:
            begin
                cmd_pop = 1'b0;
            end
        endcase
        // the 64th byte of a block also loads the working variables
        ctl.start = ctl.shift_byte && (fill_reg == FILL_LAST);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_PAD_ONE)
        begin
            len_reg <= {count_reg, 3'b000};
        end
        else if (state_reg == ST_PAD_LEN)
        begin
            len_reg <= {len_reg[55:0], 8'h00};
        end

        if (out_load)
        begin
            digest_reg <= chain[emit_reg];
            index_reg  <= emit_reg;
            last_reg   <= (emit_reg == WORD_LAST);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ret_reg       <= ST_IDLE;
            round_reg     <= '0;
            fill_reg      <= '0;
            count_reg     <= '0;
            emit_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            if (ctl.round)
            begin
                round_reg <= round_reg + 1'b1;
            end
            if (ctl.shift_byte)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            if (state_reg == ST_PAD_ONE)
            begin
                count_reg <= '0;
            end
            else if (state_reg == ST_IDLE && cmd_valid && cmd.byte_present)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (out_load)
            begin
                emit_reg      <= emit_reg + 1'b1;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign digest_word = digest_reg;
    assign word_index  = index_reg;
    assign last_word   = last_reg;

endmodule

`default_nettype wire

[rtl/sha256_byte_stream_hash.sv]
// Bytes go one per cycle into a 4-entry queue while it has room; the back
// end takes one byte per cycle while idle, and every 64th byte starts the
// 64 rounds plus the update. End of message: the padding bytes, with the
// length spilling into a second block when it does not fit, a compression
// per block, then eight digest words, one per cycle while out_ready is high.
// Asynchronous active-low reset empties the queue and restores the chain.
// ============================================================================
// sha256_byte_stream_hash
// SHA-256 over a byte stream, digest out as eight 32-bit words.
// ============================================================================
`default_nettype none

module sha256_byte_stream_hash (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        byte_present,
    input  wire logic        end_of_message,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             last_word
);
    import s256_pkg::*;

    logic        cmd_valid;
    s256_cmd_t   cmd;
    logic        cmd_pop;
    s256_ctl_t   ctl;
    s256_words_t chain;

    s256_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .cmd_valid      (cmd_valid),
        .cmd            (cmd),
        .cmd_pop        (cmd_pop)
    );

    s256_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd         (cmd),
        .cmd_pop     (cmd_pop),
        .ctl         (ctl),
        .chain       (chain),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );

    s256_compress u_compress (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .chain (chain)
    );

    // a digest always starts at word 0
    a_first_word: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> (word_index == 3'd0))
        else $error("digest did not start at word 0");

    // words follow back to back in order once the digest has started
    a_word_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last_word) |=>
            (out_valid && word_index == $past(word_index) + 3'd1))
        else $error("digest word out of order");

    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_word == (word_index == 3'd7)))
        else $error("last word flag mismatch");

endmodule

`default_nettype wire

[tb/sha256_digest_checker.sv]
// ============================================================================
// sha256_digest_checker
// Watches both channels of the byte stream hash, keeps its own SHA-256 state
// per accepted transfer and compares every digest word against the oldest
// expected word.
// ============================================================================

module sha256_digest_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        end_of_message,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] digest_word,
    input  logic [2:0]  word_index,
    input  logic        last_word,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] PAD_MARK  = 8'h80;
    localparam int         LEN_FIELD = 56;

    localparam logic [31:0] SHA_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] SHA_H0 [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_word_t;

    digest_word_t digest_q [$];

    logic [31:0] chain [8];
    logic [7:0]  blk [64];
    logic [60:0] msg_len;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_blk();
        logic [31:0] w [64];
        logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
        for (int i = 0; i < 16; i++)
        begin
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        end
        for (int i = 16; i < 64; i++)
        begin
            s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
        e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
        for (int i = 0; i < 64; i++)
        begin
            t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
                 + SHA_K[i] + w[i];
            t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
            h = g; g = f; f = e; e = d + t1;
            d = c; c = b; b = a; a = t1 + t2;
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
        chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
    endtask

    // one accepted input transfer: absorb the byte, then pad and queue the
    // digest if the message ends here
    task automatic absorb_item(input logic [7:0] b, input logic p, input logic eom);
        logic [5:0]   fill;
        logic [63:0]  bit_len;
        digest_word_t exp_w;
        if (p)
        begin
            fill = msg_len[5:0];
            blk[fill] = b;
            msg_len = msg_len + 61'd1;
            if (fill == 6'd63)
                compress_blk();
        end
        if (eom)
        begin
            fill = msg_len[5:0];
            blk[fill] = PAD_MARK;
            for (int q = fill + 1; q < 64; q++)
                blk[q] = 8'h00;
            // no room left for the length field: spill into an extra block
            if (fill >= LEN_FIELD)
            begin
                compress_blk();
                for (int q = 0; q < 64; q++)
                    blk[q] = 8'h00;
            end
            bit_len = {msg_len, 3'b000};
            for (int q = 0; q < 8; q++)
                blk[LEN_FIELD + q] = bit_len[8*(7-q) +: 8];
            compress_blk();
            for (int q = 0; q < 8; q++)
            begin
                exp_w.word = chain[q];
                exp_w.idx  = q[2:0];
                exp_w.last = (q == 7);
                digest_q = {digest_q, exp_w};
            end
            chain = SHA_H0;
            msg_len = '0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : monitor
        digest_word_t exp_w;
        logic         bad;
        if (!rst_n)
        begin
            chain = SHA_H0;
            msg_len = '0;
            digest_q.delete();
            pending = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (digest_q.size() == 0)
                begin
                    $display("%0t: unexpected digest transfer: got word %h index %0d last %0b",
                             $time, digest_word, word_index, last_word);
                    fail_count++;
                end
                else
                begin
                    exp_w = digest_q.pop_front();
                    bad = 1'b0;
                    if (digest_word !== exp_w.word)
                    begin
                        $display("%0t: digest_word mismatch: expected %h, got %h",
                                 $time, exp_w.word, digest_word);
                        bad = 1'b1;
                    end
                    if (word_index !== exp_w.idx)
                    begin
                        $display("%0t: word_index mismatch: expected %0d, got %0d",
                                 $time, exp_w.idx, word_index);
                        bad = 1'b1;
                    end
                    if (last_word !== exp_w.last)
                    begin
                        $display("%0t: last_word mismatch: expected %0b, got %0b",
                                 $time, exp_w.last, last_word);
                        bad = 1'b1;
                    end
                    if (bad)
                        fail_count++;
                end
            end
            if (in_valid && in_ready)
                absorb_item(data_byte, byte_present, end_of_message);
            pending = digest_q.size();
        end
    end

endmodule

[tb/tb_top.sv]
// ============================================================================
// tb_top
// Byte stream hash test: directed corner messages, then random messages
// around the block boundaries, with random stalls on both channels and one
// long output hold-off that backs the input up.
// ============================================================================

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET    = 410;
    localparam int QUIET_ITEMS    = 60;
    localparam int HOLD_CYCLES    = 600;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int TAIL_CYCLES    = 200;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        in_valid       = 1'b0;
    logic [7:0]  data_byte      = 8'h00;
    logic        byte_present   = 1'b0;
    logic        end_of_message = 1'b0;
    logic        out_ready      = 1'b0;
    logic        in_ready;
    logic        out_valid;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    int fail_count;
    int pending;
    int items_sent = 0;
    bit quiet      = 1'b0;
    bit hold_req   = 1'b0;

    sha256_byte_stream_hash u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .digest_word    (digest_word),
        .word_index     (word_index),
        .last_word      (last_word)
    );

    sha256_digest_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .digest_word    (digest_word),
        .word_index     (word_index),
        .last_word      (last_word),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // one input transfer, optionally preceded by an idle burst
    task automatic send_item(input logic [7:0] b, input logic p, input logic e);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 17);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid       <= 1'b1;
        data_byte      <= b;
        byte_present   <= p;
        end_of_message <= e;
        do @(posedge clk); while (!in_ready);
        if (p || e)
            items_sent++;
        quiet = (items_sent >= ITEM_TARGET - QUIET_ITEMS);
    endtask

    // random bytes; the end rides on the last byte or comes as a bare item
    task automatic send_message(input int len, input bit noisy);
        logic join_end;
        join_end = (len > 0) && ($urandom_range(0, 1) == 1);
        for (int i = 0; i < len; i++)
        begin
            if (noisy && $urandom_range(0, 9) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(0, 255)), 1'b1, join_end && (i == len - 1));
        end
        if (!join_end)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    initial
    begin : stimulus
        int r;
        int len;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_item(8'h00, 1'b0, 1'b1);    // empty message
        send_item(8'hff, 1'b0, 1'b0);    // nothing at all
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);    // last byte carries the end
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'hff, 1'b0, 1'b1);    // bare end with junk in data_byte
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'hff, 1'b0, 1'b1);

        // digests pile up behind the long hold-off and the input backs up
        hold_req = 1'b1;
        repeat (6) send_message($urandom_range(0, 3), 1'b0);

        while (items_sent < ITEM_TARGET)
        begin
            r = $urandom_range(0, 9);
            if (r < 4)
                len = $urandom_range(0, 8);
            else if (r < 8)
            begin
                case ($urandom_range(0, 5))
                    0:       len = 55;
                    1:       len = 56;
                    2:       len = 57;
                    3:       len = 63;
                    4:       len = 64;
                    default: len = 65;
                endcase
            end
            else if (r == 8)
                len = $urandom_range(9, 130);
            else
                len = 0;
            send_message(len, 1'b1);
        end
        @(negedge clk);
        in_valid <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin : receiver
        int n;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (quiet)
                out_ready <= 1'b1;
            else if ($urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 17);
                out_ready <= 1'b0;
                repeat (n - 1) @(negedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(0, 20)) @(negedge clk);
            end
        end
    end

    // ends the run once no transfer has happened on either side for too long
    initial
    begin : watchdog
        int idle;
        idle = 0;
        while (idle < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle = 0;
            else
                idle++;
        end
        $display("simulation failed");
        $finish;
    end

endmodule
